@@ rtl/array_list_insert_delete_search_macros.svh @@
// Assertion macros shared by the list RTL.
`ifndef ARRAY_LIST_INSERT_DELETE_SEARCH_MACROS_SVH
`define ARRAY_LIST_INSERT_DELETE_SEARCH_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ALIDS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list check failed");

// Next-cycle implication, disabled in reset.
`define ALIDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list check failed");

`endif

@@ rtl/alids_pkg.sv @@
// Types and constants for the ordered list block.
`default_nettype none
package alids_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int POS_W  = 4;
    localparam int OP_W   = 3;
    localparam int ST_W   = 3;
    localparam int FIDX_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_POS   = 3'd1,
        OP_APPEND    = 3'd2,
        OP_DELETE    = 3'd3,
        OP_FIND      = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // Per-cell move control: load new word, take left neighbor, take right neighbor.
    typedef struct packed {
        logic load;
        logic take_prev;
        logic take_next;
    } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/alids_cell.sv @@
// One list entry: holds a word, shifts with its neighbors, compares against the key.
`default_nettype none
module alids_cell (
    input  wire logic                           clk,
    input  wire alids_pkg::cell_ctrl_t          ctrl,
    input  wire logic [alids_pkg::WORD_W-1:0]   value,
    input  wire logic [alids_pkg::WORD_W-1:0]   prev_data,
    input  wire logic [alids_pkg::WORD_W-1:0]   next_data,
    output logic      [alids_pkg::WORD_W-1:0]   data,
    output logic                                hit
);

    logic [alids_pkg::WORD_W-1:0] data_reg;
    logic [alids_pkg::WORD_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = value;
        end
        else if (ctrl.take_prev)
        begin
            data_next = prev_data;
        end
        else if (ctrl.take_next)
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign hit  = (data_reg == value);

endmodule
`default_nettype wire

@@ rtl/alids_first_hit.sv @@
// Lowest-index priority encoder over the registered match vector.
`default_nettype none
module alids_first_hit (
    input  wire logic [alids_pkg::DEPTH-1:0]  hits,
    output logic      [alids_pkg::IDX_W-1:0]  idx,
    output logic                              any
);

    always_comb
    begin
        idx = '0;
        for (int i = alids_pkg::DEPTH - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                idx = alids_pkg::IDX_W'(i);
            end
        end
    end

    assign any = |hits;

endmodule
`default_nettype wire

@@ rtl/array_list_insert_delete_search.sv @@
// Top level of the ordered list: control, count, cell row and result stage.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------
//  command  | start, busy         | opcode, position, value
//  result   | done (1-cycle beat) | status, found_index, entry_total,
//           |                     | full_flag, empty_flag
//
// A command beat is taken on any edge with start high and busy low; one beat
// per cycle is sustained. The command edge moves the cell row and registers
// every cell's key match in stage 1; stage 2 resolves the lowest matching
// index and registers the result.
// busy is high only during reset and until the first clock edge after it.
// The receiver cannot stall; done lasts exactly one cycle per result.
`default_nettype none
`include "array_list_insert_delete_search_macros.svh"
module array_list_insert_delete_search (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [alids_pkg::OP_W-1:0]      opcode,
    input  wire logic [alids_pkg::POS_W-1:0]     position,
    input  wire logic signed [alids_pkg::WORD_W-1:0] value,
    output logic                                 done,
    output logic      [alids_pkg::ST_W-1:0]      status,
    output logic      [alids_pkg::FIDX_W-1:0]    found_index,
    output logic      [alids_pkg::CNT_W-1:0]     entry_total,
    output logic                                 full_flag,
    output logic                                 empty_flag
);

    localparam int DEPTH = alids_pkg::DEPTH;
    localparam int CNT_W = alids_pkg::CNT_W;
    localparam int IDX_W = alids_pkg::IDX_W;
    localparam int WORD_W = alids_pkg::WORD_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // ---------------- control state ----------------
    logic                  busy_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  accept;

    // stage 1: after the row update
    logic                  s1_valid_reg;
    logic                  s1_find_reg;
    alids_pkg::status_t    s1_status_reg;
    logic [DEPTH-1:0]      s1_hits_reg;
    logic [CNT_W-1:0]      s1_total_reg;

    // stage 2: result registers
    logic                  done_reg;
    alids_pkg::status_t    status_reg;
    logic [alids_pkg::FIDX_W-1:0] found_reg;
    logic [CNT_W-1:0]      total_reg;

    // ---------------- command decode ----------------
    alids_pkg::status_t    cmd_status;
    logic                  do_ins;
    logic                  do_del;
    logic                  do_find;
    logic [CNT_W-1:0]      ins_pos;
    logic [CNT_W-1:0]      del_pos;
    logic [CNT_W-1:0]      pos_ext;
    logic                  list_full;
    logic                  list_empty;

    assign accept     = start && !busy_reg;
    assign list_full  = (count_reg == DEPTH_CNT);
    assign list_empty = (count_reg == '0);
    assign pos_ext    = CNT_W'(position);

    always_comb
    begin
        cmd_status = alids_pkg::ST_OK;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        do_find    = 1'b0;
        ins_pos    = '0;
        del_pos    = pos_ext;
        unique case (opcode)
            alids_pkg::OP_INS_FRONT:
            begin
                if (list_full)
                begin
                    cmd_status = alids_pkg::ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            alids_pkg::OP_INS_POS:
            begin
                if (list_full)
                begin
                    cmd_status = alids_pkg::ST_FULL;
                end
                else if (list_empty)
                begin
                    do_ins = 1'b1;      // empty list: goes to the head whatever the position
                end
                else if (pos_ext > count_reg)
                begin
                    cmd_status = alids_pkg::ST_BADPOS;
                end
                else
                begin
                    do_ins  = 1'b1;
                    ins_pos = pos_ext;
                end
            end
            alids_pkg::OP_APPEND:
            begin
                if (list_full)
                begin
                    cmd_status = alids_pkg::ST_FULL;
                end
                else
                begin
                    do_ins  = 1'b1;
                    ins_pos = count_reg;
                end
            end
            alids_pkg::OP_DELETE:
            begin
                if (list_empty)
                begin
                    cmd_status = alids_pkg::ST_EMPTY;
                end
                else if (pos_ext >= count_reg)
                begin
                    cmd_status = alids_pkg::ST_BADPOS;
                end
                else
                begin
                    do_del = 1'b1;
                end
            end
            alids_pkg::OP_FIND:
            begin
                if (list_empty)
                begin
                    cmd_status = alids_pkg::ST_EMPTY;
                end
                else
                begin
                    do_find = 1'b1;
                end
            end
            default:
            begin
                // unused opcodes leave the list alone
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept && do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (accept && do_del)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // ---------------- cell row ----------------
    // Insert: cells above the slot up to one above the old tail take their left neighbor,
    // the slot loads the new word. Delete: cells from the slot to one below the
    // old tail take their right neighbor.
    logic [WORD_W-1:0]     cell_data [DEPTH];
    logic [DEPTH-1:0]      cell_hit;
    logic [DEPTH-1:0]      hit_live;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] CI  = CNT_W'(i);
        localparam logic [CNT_W-1:0] CI1 = CNT_W'(i + 1);

        alids_pkg::cell_ctrl_t ctrl;
        logic [WORD_W-1:0]     prev_d;
        logic [WORD_W-1:0]     next_d;

        assign ctrl = '{
            load:      accept && do_ins && (CI == ins_pos),
            take_prev: accept && do_ins && (CI > ins_pos) && (CI <= count_reg),
            take_next: accept && do_del && (CI >= del_pos) && (CI1 < count_reg)
        };

        if (i == 0)
        begin : g_head
            assign prev_d = value;
        end
        else
        begin : g_body
            assign prev_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_d = cell_data[i];
        end
        else
        begin : g_mid
            assign next_d = cell_data[i+1];
        end

        alids_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .value     (value),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[i]),
            .hit       (cell_hit[i])
        );

        // only entries below the count take part in a search
        assign hit_live[i] = cell_hit[i] && (CI < count_reg);
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            busy_reg     <= 1'b0;
            count_reg    <= count_next;
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
        end
    end

    // ---------------- stage 1 payload ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_find_reg   <= do_find;
            s1_status_reg <= cmd_status;
            s1_hits_reg   <= hit_live;
            s1_total_reg  <= count_next;
        end
    end

    // ---------------- stage 2: resolve search ----------------
    logic [IDX_W-1:0] first_idx;
    logic             first_any;

    alids_first_hit u_first_hit (
        .hits (s1_hits_reg),
        .idx  (first_idx),
        .any  (first_any)
    );

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            total_reg <= s1_total_reg;
            if (s1_find_reg)
            begin
                status_reg <= first_any ? alids_pkg::ST_OK : alids_pkg::ST_NOTFOUND;
                found_reg  <= first_any ? alids_pkg::FIDX_W'(first_idx) : '0;
            end
            else
            begin
                status_reg <= s1_status_reg;
                found_reg  <= '0;
            end
        end
    end

    // ---------------- outputs ----------------
    assign busy        = busy_reg;
    assign done        = done_reg;
    assign status      = status_reg;
    assign found_index = found_reg;
    assign entry_total = total_reg;
    assign full_flag   = (total_reg == DEPTH_CNT);
    assign empty_flag  = (total_reg == '0);

    // ---------------- assertions ----------------
    `ALIDS_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_CNT)
    `ALIDS_ASSERT_NEXT(a_result_follows, clk, rst_n, s1_valid_reg, done_reg)
    `ALIDS_ASSERT_IMPLY(a_found_only_ok, clk, rst_n, done && (found_index != '0), status == alids_pkg::ST_OK)
    `ALIDS_ASSERT_IMPLY(a_flags_apart, clk, rst_n, done, !(full_flag && empty_flag))

endmodule
`default_nettype wire
